### sv/fla_pkg.sv
// Shared types and constants of the free-list ID allocator.
package fla_pkg;

  localparam int FlaCapacity = 1024;
  localparam int PoolSizeW = 11;
  localparam int NumberW = 16;
  localparam int GrantW = 10;
  localparam int PaddrW = 3;
  localparam int PdataW = 32;
  localparam logic [PoolSizeW-1:0] PoolSizeReset = 11'd1024;
  localparam logic [PaddrW-3:0] RegPoolSize = 1'd0;

  typedef enum logic [1:0] {
    OpGet = 2'd0,
    OpCheck = 2'd1,
    OpRelease = 2'd2
  } op_e;

  typedef struct packed {
    logic accept;
    logic exec;
    logic clr_start;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic clr_last;
  } sts_t;

endpackage

### sv/fla_ctrl.sv
// Controller state machine of the free-list ID allocator.
module fla_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          cfg_wr_i,
  input  fla_pkg::sts_t sts_i,
  output fla_pkg::cmd_t cmd_o,
  output logic          in_stall_o
);

  localparam logic [1:0] StClr = 2'd0;
  localparam logic [1:0] StIdle = 2'd1;
  localparam logic [1:0] StExec = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      StClr: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_stall_o = cfg_wr_i;
        if (in_valid_i && !cfg_wr_i) begin
          cmd_o.accept = 1'b1;
          state_d = StExec;
        end
      end
      StExec: begin
        if (!sts_i.out_busy) begin
          cmd_o.exec = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StClr;
      end
    endcase
    if (cfg_wr_i) begin
      cmd_o.clr_start = 1'b1;
      cmd_o.clr_step = 1'b0;
      state_d = StClr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == StExec || state_q == StClr)
    else $error("accepted transfer did not enter execute");
  a_clr_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StClr |-> in_stall_o && !cmd_o.accept)
    else $error("input taken during clearing sweep");
  a_exec_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> $past(cmd_o.accept) || $past(state_q) == StExec)
    else $error("execute without accepted item");
`endif

endmodule

### sv/fla_dp.sv
// Datapath of the free-list ID allocator: stack, free map, pointer and result register.
module fla_dp #(
  parameter int Capacity = fla_pkg::FlaCapacity
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fla_pkg::cmd_t                cmd_i,
  output fla_pkg::sts_t                sts_o,
  input  logic [fla_pkg::PoolSizeW-1:0] pool_size_i,
  input  logic [1:0]                   op_i,
  input  logic [fla_pkg::NumberW-1:0]  number_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [fla_pkg::GrantW-1:0]   granted_id_o,
  output logic                         success_o
);

  localparam int IdW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CntW = $clog2(Capacity + 1);
  localparam int CmpW = (CntW > fla_pkg::NumberW) ? CntW : fla_pkg::NumberW;
  localparam int GW = fla_pkg::GrantW;
  localparam int NW = fla_pkg::NumberW;

  logic [IdW-1:0] stk_mem [Capacity];
  logic           map_mem [Capacity];

  logic [IdW-1:0]  stk_rd_q;
  logic            map_rd_q;
  logic [1:0]      op_q;
  logic [NW-1:0]   num_q;
  logic [CntW-1:0] sp_q, sp_d;
  logic [CntW-1:0] maxsp_q, maxsp_d;
  logic [IdW-1:0]  clr_q, clr_d;
  logic            out_valid_q, out_valid_d;
  logic [GW-1:0]   granted_q, granted_d;
  logic            success_q, success_d;

  logic [CmpW-1:0] pool_ext;
  logic [CmpW-1:0] size_w;
  logic [CmpW-1:0] sp_ext;
  logic [CmpW-1:0] num_ext;
  logic            num_in_range;
  logic [IdW-1:0]  pop_id;
  logic            get_ok, chk_ok, rel_ok;
  logic            stk_we;
  logic [IdW-1:0]  stk_waddr;
  logic            map_we;
  logic [IdW-1:0]  map_waddr;
  logic            map_wdata;

  always_comb begin
    pool_ext = CmpW'(pool_size_i);
    size_w = (pool_ext > CmpW'(Capacity)) ? CmpW'(Capacity) : pool_ext;
    sp_ext = CmpW'(sp_q);
    num_ext = CmpW'(num_q);
    num_in_range = num_ext < size_w;
    pop_id = (sp_q < maxsp_q) ? stk_rd_q : sp_q[IdW-1:0];
    get_ok = 1'b0;
    chk_ok = 1'b0;
    rel_ok = 1'b0;
    case (op_q)
      fla_pkg::OpGet: get_ok = sp_ext < size_w;
      fla_pkg::OpCheck: chk_ok = num_in_range && map_rd_q;
      fla_pkg::OpRelease: rel_ok = num_in_range && !map_rd_q && (sp_q != '0);
      default: ;
    endcase
  end

  always_comb begin
    sp_d = sp_q;
    maxsp_d = maxsp_q;
    clr_d = clr_q;
    stk_we = 1'b0;
    stk_waddr = IdW'(sp_q - 1'b1);
    map_we = 1'b0;
    map_waddr = clr_q;
    map_wdata = 1'b1;
    if (cmd_i.clr_start) begin
      sp_d = '0;
      maxsp_d = '0;
      clr_d = '0;
    end else if (cmd_i.clr_step) begin
      map_we = 1'b1;
      clr_d = IdW'(clr_q + 1'b1);
    end else if (cmd_i.exec) begin
      if (get_ok) begin
        sp_d = CntW'(sp_q + 1'b1);
        if (sp_q == maxsp_q) begin
          maxsp_d = CntW'(maxsp_q + 1'b1);
        end
        map_we = 1'b1;
        map_waddr = pop_id;
        map_wdata = 1'b0;
      end else if (rel_ok) begin
        sp_d = CntW'(sp_q - 1'b1);
        stk_we = 1'b1;
        map_we = 1'b1;
        map_waddr = num_q[IdW-1:0];
        map_wdata = 1'b1;
      end
    end
  end

  always_comb begin
    granted_d = granted_q;
    success_d = success_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.exec) begin
      out_valid_d = 1'b1;
      granted_d = get_ok ? GW'(pop_id) : '0;
      success_d = get_ok || chk_ok || rel_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= num_q[IdW-1:0];
    end
    if (cmd_i.accept) begin
      stk_rd_q <= stk_mem[sp_q[IdW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (cmd_i.accept) begin
      map_rd_q <= map_mem[number_i[IdW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q <= op_i;
      num_q <= number_i;
    end
    granted_q <= granted_d;
    success_q <= success_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
      maxsp_q <= '0;
      clr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sp_q <= sp_d;
      maxsp_q <= maxsp_d;
      clr_q <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.out_busy = out_valid_q && out_stall_i;
  assign sts_o.clr_last = clr_q == IdW'(Capacity - 1);
  assign out_valid_o = out_valid_q;
  assign granted_id_o = granted_q;
  assign success_o = success_q;

`ifndef SYNTHESIS
  a_sp_below_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= maxsp_q)
    else $error("stack pointer above fill mark");
  a_mark_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    maxsp_q <= CntW'(Capacity))
    else $error("fill mark beyond capacity");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !cmd_i.exec)
    else $error("stalled result overwritten");
  a_get_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && !cmd_i.clr_start && get_ok |=> sp_q == CntW'($past(sp_q) + 1'b1))
    else $error("granted get did not advance the pointer");
`endif

endmodule

### sv/free_list_id_allocator.sv
// Top level of the free-list ID allocator: register port, controller and datapath.
//
//   channel | direction | handshake              | payload
//   input   | in        | in_valid_i, in_stall_o | op_i, number_i
//   output  | out       | out_valid_o, out_stall_i | granted_id_o, success_o
//   config  | in        | psel, penable, pwrite  | paddr, pwdata, prdata
//
// Each item reads stack and free map in its transfer cycle, then executes in the execute state.
// Results sit in an output register; execution waits while that register is stalled.
// After reset, and after every write of pool_size, the free map is swept to all free.
// The sweep writes each of the Capacity entries (1024 by default) and holds the input stalled.
module free_list_id_allocator #(
  parameter int Capacity = fla_pkg::FlaCapacity
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [fla_pkg::NumberW-1:0]   number_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fla_pkg::GrantW-1:0]    granted_id_o,
  output logic                          success_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fla_pkg::PaddrW-1:0]    paddr,
  input  logic [fla_pkg::PdataW-1:0]    pwdata,
  output logic [fla_pkg::PdataW-1:0]    prdata,
  output logic                          pready
);

  localparam int PsW = fla_pkg::PoolSizeW;

  logic [PsW-1:0] pool_size_q;
  logic           sel_pool;
  logic           cfg_wr;
  fla_pkg::cmd_t  cmd;
  fla_pkg::sts_t  sts;

  assign pready = 1'b1;
  assign sel_pool = paddr[fla_pkg::PaddrW-1:2] == fla_pkg::RegPoolSize;
  assign cfg_wr = psel && penable && pwrite && sel_pool;
  assign prdata = sel_pool ? fla_pkg::PdataW'(pool_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= fla_pkg::PoolSizeReset;
    end else if (cfg_wr) begin
      pool_size_q <= pwdata[PsW-1:0];
    end
  end

  fla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cfg_wr_i   (cfg_wr),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  fla_dp #(
    .Capacity (Capacity)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .pool_size_i  (pool_size_q),
    .op_i         (op_i),
    .number_i     (number_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .granted_id_o (granted_id_o),
    .success_o    (success_o)
  );

endmodule
